[design/max_min_fair_allocation_top_assert.svh]
// ----------------------------------------------------------------------------
// max_min_fair_allocation_top_assert.svh
// Assertion macros shared by the fair allocation RTL. Both forms clock on clk
// and are disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MAX_MIN_FAIR_ALLOCATION_TOP_ASSERT_SVH
`define MAX_MIN_FAIR_ALLOCATION_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define MMFA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mmfa assertion failed");

// next-cycle implication
`define MMFA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mmfa assertion failed");

`else

`define MMFA_ASSERT_NOW(lbl, ante, cons)
`define MMFA_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

[design/mmfa_pkg.sv]
// ----------------------------------------------------------------------------
// mmfa_pkg
// Sizes and beat types of the max-min fair allocation block.
// ----------------------------------------------------------------------------
`default_nettype none

package mmfa_pkg;

  localparam int MAX_MEMBERS = 64;
  localparam int DATA_W      = 32;
  localparam int IDX_W       = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1;
  localparam int CNT_W       = $clog2(MAX_MEMBERS + 1);
  localparam int OUT_IDX_W   = 6;

  typedef struct packed {
    logic [DATA_W-1:0] capacity;
    logic              last_capacity;
  } in_beat_t;

  typedef struct packed {
    logic [OUT_IDX_W-1:0] member_index;
    logic [DATA_W-1:0]    allocation;
    logic                 last_allocation;
  } out_beat_t;

endpackage

`default_nettype wire

[design/max_min_fair_allocation_top.sv]
// ----------------------------------------------------------------------------
// max_min_fair_allocation_top
// Max-min fair (water filling) share of a configured total among loaded
// members.
// ----------------------------------------------------------------------------
// Capacities load one beat per cycle while busy is low; the beat flagged last,
// or the MAX_MEMBERS-th beat, raises busy and starts the run. Each pass takes
// one division of the remaining amount by the active count, then one read of
// the capacity memory per member; a run of N members takes between one and N
// passes. Results then leave one per cycle in load order on out_strobe, which
// the receiver cannot hold off; busy falls in the cycle of the last result and
// the next set may load. The user writes target_total through cfg_we / cfg_wdata
// only while busy is low; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none
`include "max_min_fair_allocation_top_assert.svh"

module max_min_fair_allocation_top import mmfa_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  in_beat_t          in_data,
  input  logic              cfg_we,
  input  logic [DATA_W-1:0] cfg_wdata,
  output logic              out_strobe,
  output out_beat_t         out_data
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_SCAN,
    ST_OUT
  } state_t;

  state_t                 state_r,      state_nxt;
  logic [DATA_W-1:0]      target_r,     target_nxt;
  logic [CNT_W-1:0]       cnt_r,        cnt_nxt;
  logic [CNT_W-1:0]       n_r,          n_nxt;
  logic [DATA_W-1:0]      rem_r,        rem_nxt;
  logic [CNT_W-1:0]       act_cnt_r,    act_cnt_nxt;
  logic [DATA_W-1:0]      share_r,      share_nxt;
  logic [CNT_W-1:0]       idx_r,        idx_nxt;
  logic                   rd_v_r,       rd_v_nxt;
  logic [IDX_W-1:0]       rd_i_r,       rd_i_nxt;
  logic                   retired_r,    retired_nxt;
  logic                   out_strobe_r, out_strobe_nxt;
  out_beat_t              out_data_r,   out_data_nxt;

  // top bit: member still active in the current run
  logic [DATA_W:0]   cap_mem [MAX_MEMBERS];
  logic [DATA_W:0]   rd_data_r;

  logic              load;
  logic              rd_req;
  logic              rd_act;
  logic [DATA_W-1:0] rd_cap;
  logic              hit;
  logic              rd_last;
  logic [CNT_W-1:0]  n_load;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_wa;
  logic [DATA_W:0]   mem_wd;
  logic              div_start;
  logic              div_done;
  logic [DATA_W-1:0] div_q;

  assign load    = start && !busy;
  assign n_load  = cnt_r + CNT_W'(1);
  assign rd_req  = (state_r == ST_SCAN || state_r == ST_OUT) && idx_r != n_r;
  assign rd_act  = rd_data_r[DATA_W];
  assign rd_cap  = rd_data_r[DATA_W-1:0];
  assign hit     = rd_v_r && rd_act && rd_cap <= share_r;
  assign rd_last = CNT_W'(rd_i_r) == n_r - CNT_W'(1);

  assign mem_we  = load || (state_r == ST_SCAN && hit);
  assign mem_wa  = load ? cnt_r[IDX_W-1:0] : rd_i_r;
  assign mem_wd  = load ? {1'b1, in_data.capacity} : {1'b0, rd_cap};

  mmfa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (rem_r),
    .divisor  (act_cnt_r),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (mem_we) begin
      cap_mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= cap_mem[idx_r[IDX_W-1:0]];
  end

  always_comb begin
    state_nxt      = state_r;
    target_nxt     = cfg_we ? cfg_wdata : target_r;
    cnt_nxt        = cnt_r;
    n_nxt          = n_r;
    rem_nxt        = rem_r;
    act_cnt_nxt    = act_cnt_r;
    share_nxt      = share_r;
    idx_nxt        = idx_r;
    rd_v_nxt       = rd_req;
    rd_i_nxt       = idx_r[IDX_W-1:0];
    retired_nxt    = retired_r;
    out_strobe_nxt = 1'b0;
    out_data_nxt   = out_data_r;
    div_start      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (load) begin
          if (in_data.last_capacity || cnt_r == CNT_W'(MAX_MEMBERS - 1)) begin
            n_nxt       = n_load;
            act_cnt_nxt = n_load;
            rem_nxt     = target_r;
            cnt_nxt     = '0;
            state_nxt   = ST_DIV_GO;
          end else begin
            cnt_nxt = n_load;
          end
        end
      end
      ST_DIV_GO: begin
        div_start = 1'b1;
        state_nxt = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          share_nxt   = div_q;
          idx_nxt     = '0;
          retired_nxt = 1'b0;
          state_nxt   = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (rd_req) begin
          idx_nxt = idx_r + CNT_W'(1);
        end
        if (hit) begin
          rem_nxt     = rem_r - rd_cap;
          act_cnt_nxt = act_cnt_r - CNT_W'(1);
          retired_nxt = 1'b1;
        end
        // pass over: loop again only if someone retired and some remain
        if (!rd_req && !rd_v_r) begin
          idx_nxt = '0;
          if (retired_r && act_cnt_r != '0) begin
            state_nxt = ST_DIV_GO;
          end else begin
            state_nxt = ST_OUT;
          end
        end
      end
      ST_OUT: begin
        if (rd_req) begin
          idx_nxt = idx_r + CNT_W'(1);
        end
        if (rd_v_r) begin
          out_strobe_nxt               = 1'b1;
          out_data_nxt.member_index    = OUT_IDX_W'(rd_i_r);
          out_data_nxt.allocation      = rd_act ? share_r : rd_cap;
          out_data_nxt.last_allocation = rd_last;
          if (rd_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      target_r     <= '0;
      cnt_r        <= '0;
      n_r          <= '0;
      rem_r        <= '0;
      act_cnt_r    <= '0;
      idx_r        <= '0;
      rd_v_r       <= 1'b0;
      retired_r    <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      target_r     <= target_nxt;
      cnt_r        <= cnt_nxt;
      n_r          <= n_nxt;
      rem_r        <= rem_nxt;
      act_cnt_r    <= act_cnt_nxt;
      idx_r        <= idx_nxt;
      rd_v_r       <= rd_v_nxt;
      retired_r    <= retired_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
    share_r    <= share_nxt;
    rd_i_r     <= rd_i_nxt;
    out_data_r <= out_data_nxt;
  end

  assign busy       = state_r != ST_IDLE;
  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

  `MMFA_ASSERT_NEXT(a_last_beat_runs, load && in_data.last_capacity, busy)
  `MMFA_ASSERT_NOW(a_div_nonzero, div_start, act_cnt_r != '0)
  `MMFA_ASSERT_NEXT(a_out_burst, out_strobe_r && !out_data_r.last_allocation, out_strobe_r)
  `MMFA_ASSERT_NOW(a_out_last_idle, out_strobe_r && out_data_r.last_allocation,
                   state_r == ST_IDLE)

endmodule

`default_nettype wire

[design/mmfa_div.sv]
// ----------------------------------------------------------------------------
// mmfa_div
// Restoring divider, one quotient bit per cycle: amount / active count.
// ----------------------------------------------------------------------------
`default_nettype none
`include "max_min_fair_allocation_top_assert.svh"

module mmfa_div import mmfa_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DATA_W-1:0] dividend,
  input  logic [CNT_W-1:0]  divisor,
  output logic              done,
  output logic [DATA_W-1:0] quotient
);

  localparam int STEP_W = (DATA_W > 1) ? $clog2(DATA_W) : 1;

  logic              run_r,  run_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [CNT_W-1:0]  rem_r,  rem_nxt;
  logic [CNT_W-1:0]  dvs_r,  dvs_nxt;
  logic [DATA_W-1:0] quo_r,  quo_nxt;
  logic [CNT_W:0]    rem_sh;
  logic [CNT_W:0]    rem_sub;

  assign rem_sh  = {rem_r, quo_r[DATA_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_r};

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    if (start) begin
      run_nxt  = 1'b1;
      step_nxt = STEP_W'(DATA_W - 1);
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      quo_nxt  = dividend;
    end else if (run_r) begin
      if (rem_sh >= {1'b0, dvs_r}) begin
        rem_nxt = rem_sub[CNT_W-1:0];
        quo_nxt = {quo_r[DATA_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[CNT_W-1:0];
        quo_nxt = {quo_r[DATA_W-2:0], 1'b0};
      end
      if (step_r == '0) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end else begin
        step_nxt = step_r - STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    step_r <= step_nxt;
    rem_r  <= rem_nxt;
    dvs_r  <= dvs_nxt;
    quo_r  <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

  `MMFA_ASSERT_NEXT(a_div_start_runs, start, run_r)
  `MMFA_ASSERT_NOW(a_div_done_idle, done_r, !run_r)
  `MMFA_ASSERT_NEXT(a_div_last_step, run_r && !start && step_r == '0, done_r && !run_r)

endmodule

`default_nettype wire
